/* hdl/tdsr_pkg.sv */
// tdsr_pkg: shared types, codes and constants of the tile depth-stencil store
// used by tdsr_frag_test, tdsr_lane_div and the core module; depends on nothing

package tdsr_pkg;

    // field widths fixed by the interface
    localparam int DEPTH_W   = 24;
    localparam int STEN_W    = 8;
    localparam int COLOR_W   = 32;
    localparam int PIX_W     = 10;
    localparam int SMP_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int SCNT_W    = 3;

    // resolve arithmetic: up to eight samples of one byte lane
    localparam int LANES       = 4;
    localparam int LANE_W      = 8;
    localparam int SUM_W       = 11;
    localparam int NS_W        = 4;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 14;

    // request codes
    localparam logic [1:0] REQ_FRAG    = 2'd0;
    localparam logic [1:0] REQ_CLEAR   = 2'd1;
    localparam logic [1:0] REQ_RESOLVE = 2'd2;

    // stencil function codes
    localparam logic [1:0] SFN_ALWAYS = 2'd0;
    localparam logic [1:0] SFN_EQUAL  = 2'd1;
    localparam logic [1:0] SFN_NEQUAL = 2'd2;

    // stencil operation codes
    localparam logic [1:0] SOP_KEEP    = 2'd0;
    localparam logic [1:0] SOP_REPLACE = 2'd1;
    localparam logic [1:0] SOP_INCR    = 2'd2;
    localparam logic [1:0] SOP_ZERO    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_COLOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DEPTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_STENCIL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEN_RESOLVE  = 3'd4;

    localparam logic [STEN_W-1:0] STEN_MAX = 8'hFF;

    // fragment command as seen by the test unit
    typedef struct packed {
        logic               st_en;
        logic [1:0]         st_func;
        logic [STEN_W-1:0]  st_ref;
        logic [1:0]         st_op;
        logic [DEPTH_W-1:0] depth;
    } t_frag_cmd;

    // test outcome and the depth-stencil word to store
    typedef struct packed {
        logic               pass;
        logic [COLOR_W-1:0] ds_word;
    } t_frag_res;

    // ceil(2^14 / n): exact floor division of an 11-bit sum by n in 1..8
    function automatic logic [RECIP_W-1:0] f_recip(input logic [NS_W-1:0] ns);
        logic [RECIP_W-1:0] m;
        case (ns)
            4'd1:    m = 15'd16384;
            4'd2:    m = 15'd8192;
            4'd3:    m = 15'd5462;
            4'd4:    m = 15'd4096;
            4'd5:    m = 15'd3277;
            4'd6:    m = 15'd2731;
            4'd7:    m = 15'd2341;
            4'd8:    m = 15'd2048;
            default: m = 15'd16384;
        endcase
        return m;
    endfunction

endpackage

/* hdl/tdsr_ram.sv */
// tdsr_ram: generic single-clock RAM, one write port, one registered read port
// no dependencies

module tdsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tdsr_frag_test.sv */
// tdsr_frag_test: stencil test, strict-less depth test and stencil update
// for one sample; uses tdsr_pkg

module tdsr_frag_test (
    input  tdsr_pkg::t_frag_cmd  i_cmd,
    input  logic [31:0]          i_ds_word,
    output tdsr_pkg::t_frag_res  o_res
);
    import tdsr_pkg::*;

    logic [STEN_W-1:0]  sten;
    logic [DEPTH_W-1:0] z_stored;
    logic               st_fail;
    logic               z_pass;
    logic [STEN_W-1:0]  new_st;

    assign sten     = i_ds_word[STEN_W-1:0];
    assign z_stored = i_ds_word[STEN_W +: DEPTH_W];

    // stencil compare, unknown function passes
    always_comb begin
        case (i_cmd.st_func)
            SFN_EQUAL:  st_fail = (sten != i_cmd.st_ref);
            SFN_NEQUAL: st_fail = (sten == i_cmd.st_ref);
            default:    st_fail = 1'b0;
        endcase
    end

    assign z_pass = (i_cmd.depth < z_stored);

    // stencil update on pass
    always_comb begin
        case (i_cmd.st_op)
            SOP_REPLACE: new_st = i_cmd.st_ref;
            SOP_INCR:    new_st = (sten == STEN_MAX) ? STEN_MAX : sten + 1'b1;
            SOP_ZERO:    new_st = '0;
            default:     new_st = sten;
        endcase
    end

    assign o_res.pass    = !(i_cmd.st_en && st_fail) && z_pass;
    assign o_res.ds_word = {i_cmd.depth, new_st};

endmodule

/* hdl/tdsr_lane_div.sv */
// tdsr_lane_div: floor division of one byte-lane sum by the sample count
// by reciprocal multiply; uses tdsr_pkg

module tdsr_lane_div (
    input  logic [tdsr_pkg::SUM_W-1:0]  i_sum,
    input  logic [tdsr_pkg::NS_W-1:0]   i_ns,
    output logic [tdsr_pkg::LANE_W-1:0] o_quot
);
    import tdsr_pkg::*;

    logic [SUM_W+RECIP_W-1:0] prod;

    // sum * ceil(2^14/n) >> 14 is exact for sums below 2048
    assign prod   = (SUM_W+RECIP_W)'(i_sum) * (SUM_W+RECIP_W)'(f_recip(i_ns));
    assign o_quot = prod[RECIP_SHIFT +: LANE_W];

endmodule

/* hdl/tile_depth_stencil_resolve_core.sv */
// tile_depth_stencil_resolve_core: multisampled tile color and depth-stencil store
// uses tdsr_pkg, tdsr_ram, tdsr_frag_test, tdsr_lane_div
//
// Usage
//   Input channel (i_in_valid / o_in_ready) takes one request item: fragment,
//   clear tile or resolve pixel. Output channel (o_out_valid / i_out_ready)
//   returns exactly one result item per request, in order.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data at the clock
//   edge, no read-back; the user writes it only while the block is idle (unchecked).
// Sequencing
//   One request is in work at a time; the state lives in two RAMs with a
//   registered read port, read-modify-written by the control sequencer.
//   Fragment: read at accept, test and write in S_FRAG, result in S_DONE.
//   Resolve: one RAM read per sample for the n active samples, then one
//   byte lane divided per cycle through a single reciprocal multiplier.
//   Clear: all TILE_SIZE*TILE_SIZE*MAX_SAMPLES entries, one entry per cycle.
// Reset and stall
//   Reset returns the sequencer to idle, empties the output register and loads
//   the configuration reset values; the stores hold nothing valid until a clear.
//   A finished result waits in the output register while the next item is
//   accepted; the block then holds that item's result until the slot frees.

module tile_depth_stencil_resolve_core #(
    parameter int TILE_SIZE   = 32,
    parameter int MAX_SAMPLES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [tdsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tdsr_pkg::CFG_W-1:0]      i_cfg_data,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_req_type,
    input  logic [tdsr_pkg::PIX_W-1:0]      i_pixel_index,
    input  logic [tdsr_pkg::SMP_W-1:0]      i_sample_index,
    input  logic [tdsr_pkg::DEPTH_W-1:0]    i_frag_depth,
    input  logic [tdsr_pkg::COLOR_W-1:0]    i_frag_color,
    input  logic                            i_stencil_test_enable,
    input  logic [1:0]                      i_stencil_func,
    input  logic [tdsr_pkg::STEN_W-1:0]     i_stencil_ref,
    input  logic [1:0]                      i_stencil_op,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_written,
    output logic [tdsr_pkg::COLOR_W-1:0]    o_resolved_color,
    output logic [tdsr_pkg::STEN_W-1:0]     o_resolved_stencil
);
    import tdsr_pkg::*;

    localparam int PIXELS  = TILE_SIZE * TILE_SIZE;
    localparam int ENTRIES = PIXELS * MAX_SAMPLES;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);
    localparam logic [NS_W-1:0]   MAX_NS    = NS_W'(MAX_SAMPLES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAG,
        S_RES,
        S_DIV,
        S_CLEAR,
        S_DONE
    } t_state;

    // configuration registers
    logic [SCNT_W-1:0]  r_sample_count;
    logic [COLOR_W-1:0] r_clear_color;
    logic [DEPTH_W-1:0] r_clear_depth;
    logic [STEN_W-1:0]  r_clear_stencil;
    logic               r_sten_resolve;

    // sequencer and working registers
    t_state             r_state;
    logic [ADDR_W-1:0]  r_addr;
    t_frag_cmd          r_cmd;
    logic [COLOR_W-1:0] r_in_color;
    logic [NS_W-1:0]    r_ns;
    logic [NS_W-1:0]    r_k;
    logic [1:0]         r_lane;
    logic [SUM_W-1:0]   r_sum [LANES];
    logic [STEN_W-1:0]  r_smax;
    logic               r_pend_written;
    logic [COLOR_W-1:0] r_pend_color;
    logic [STEN_W-1:0]  r_pend_stencil;

    // output register
    logic               r_out_valid;
    logic               r_out_written;
    logic [COLOR_W-1:0] r_out_color;
    logic [STEN_W-1:0]  r_out_stencil;

    logic [SUM_W-1:0]   n_sum [LANES];
    logic [STEN_W-1:0]  n_smax;

    logic [NS_W-1:0]    ns_act;
    logic               pix_ok;
    logic               smp_ok;
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  acc_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [31:0]        ds_wdata;
    logic [COLOR_W-1:0] col_wdata;
    logic [31:0]        ds_rdata;
    logic [COLOR_W-1:0] col_rdata;
    t_frag_res          frag_res;
    logic [LANE_W-1:0]  lane_quot;
    logic               out_free;

    // active sample count, zero acts as one, clamped to MAX_SAMPLES
    always_comb begin
        if (r_sample_count == '0) begin
            ns_act = NS_W'(1);
        end else if (NS_W'(r_sample_count) > MAX_NS) begin
            ns_act = MAX_NS;
        end else begin
            ns_act = NS_W'(r_sample_count);
        end
    end

    // request decode and entry address of the incoming item
    assign pix_ok    = (32'(i_pixel_index) < 32'(PIXELS));
    assign smp_ok    = (NS_W'(i_sample_index) < ns_act);
    assign base_addr = ADDR_W'(32'(i_pixel_index) * MAX_SAMPLES);
    assign acc_addr  = base_addr +
                       ((i_req_type == REQ_FRAG) ? ADDR_W'(i_sample_index) : '0);

    // read address: incoming item while idle, else the working address
    assign rd_addr = (r_state == S_IDLE) ? acc_addr : r_addr;

    // write back on a passing fragment or during the clear sweep
    assign mem_we    = ((r_state == S_FRAG) && frag_res.pass) || (r_state == S_CLEAR);
    assign ds_wdata  = (r_state == S_CLEAR) ? {r_clear_depth, r_clear_stencil}
                                            : frag_res.ds_word;
    assign col_wdata = (r_state == S_CLEAR) ? r_clear_color : r_in_color;

    tdsr_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES)
    ) u_ds_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (ds_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ds_rdata)
    );

    tdsr_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (ENTRIES)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (col_wdata),
        .i_raddr (rd_addr),
        .o_rdata (col_rdata)
    );

    tdsr_frag_test u_frag_test (
        .i_cmd     (r_cmd),
        .i_ds_word (ds_rdata),
        .o_res     (frag_res)
    );

    tdsr_lane_div u_lane_div (
        .i_sum  (r_sum[r_lane]),
        .i_ns   (r_ns),
        .o_quot (lane_quot)
    );

    // resolve accumulation, first sample starts the sums
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_sum[i] = ((r_k == '0) ? '0 : r_sum[i]) +
                       SUM_W'(col_rdata[i*LANE_W +: LANE_W]);
        end
        if (r_k == '0 || ds_rdata[STEN_W-1:0] > r_smax) begin
            n_smax = ds_rdata[STEN_W-1:0];
        end else begin
            n_smax = r_smax;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_sample_count  <= SCNT_W'(1);
            r_clear_color   <= '0;
            r_clear_depth   <= '1;
            r_clear_stencil <= '0;
            r_sten_resolve  <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_COUNT:  r_sample_count  <= i_cfg_data[SCNT_W-1:0];
                    CFG_CLEAR_COLOR:   r_clear_color   <= i_cfg_data[COLOR_W-1:0];
                    CFG_CLEAR_DEPTH:   r_clear_depth   <= i_cfg_data[DEPTH_W-1:0];
                    CFG_CLEAR_STENCIL: r_clear_stencil <= i_cfg_data[STEN_W-1:0];
                    CFG_STEN_RESOLVE:  r_sten_resolve  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // result taken by the receiver, a finishing item refills the slot itself
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pend_written <= 1'b0;
                        r_pend_color   <= '0;
                        r_pend_stencil <= '0;
                        r_cmd          <= '{st_en:   i_stencil_test_enable,
                                            st_func: i_stencil_func,
                                            st_ref:  i_stencil_ref,
                                            st_op:   i_stencil_op,
                                            depth:   i_frag_depth};
                        r_in_color     <= i_frag_color;
                        r_ns           <= ns_act;
                        r_k            <= '0;
                        r_lane         <= '0;
                        case (i_req_type)
                            REQ_FRAG: begin
                                r_addr  <= acc_addr;
                                r_state <= (pix_ok && smp_ok) ? S_FRAG : S_DONE;
                            end
                            REQ_CLEAR: begin
                                r_addr  <= '0;
                                r_state <= S_CLEAR;
                            end
                            REQ_RESOLVE: begin
                                r_addr  <= acc_addr + 1'b1;
                                r_state <= pix_ok ? S_RES : S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FRAG: begin
                    r_pend_written <= frag_res.pass;
                    r_state        <= S_DONE;
                end
                S_RES: begin
                    for (int i = 0; i < LANES; i++) begin
                        r_sum[i] <= n_sum[i];
                    end
                    r_smax <= n_smax;
                    r_addr <= r_addr + 1'b1;
                    r_k    <= r_k + 1'b1;
                    if (r_k == r_ns - 1'b1) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_pend_color[r_lane*LANE_W +: LANE_W] <= lane_quot;
                    r_lane <= r_lane + 1'b1;
                    if (r_lane == 2'(LANES - 1)) begin
                        r_pend_stencil <= r_sten_resolve ? r_smax : '0;
                        r_state        <= S_DONE;
                    end
                end
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_written <= r_pend_written;
                        r_out_color   <= r_pend_color;
                        r_out_stencil <= r_pend_stencil;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_written          = r_out_written;
    assign o_resolved_color   = r_out_color;
    assign o_resolved_stencil = r_out_stencil;

endmodule
